### sv/mdhr_pkg.sv
// shared types and constants of the mask driven hsv recolor block
package mdhr_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUE = 2'd0,
    REG_SAT = 2'd1,
    REG_VAL = 2'd2
  } cfg_reg_t;

  // register widths
  localparam int HUE_W  = 11;
  localparam int GAIN_W = 12;

  // mask gray threshold and full channel level
  localparam logic [7:0] GRAY_BRIGHT = 8'd250;
  localparam logic [7:0] FULL        = 8'd255;

  // luma weights
  localparam logic [14:0] LUMA_WR = 15'd30;
  localparam logic [14:0] LUMA_WG = 15'd59;
  localparam logic [14:0] LUMA_WB = 15'd11;

  // divide by 100 as multiply by reciprocal, exact for sums up to 25500
  localparam logic [14:0] GRAY_RECIP = 15'd20972;
  localparam int          GRAY_SHIFT = 21;

  // divide by 510, exact for numerators up to 130305
  localparam logic [17:0] P_RECIP = 18'd131587;
  localparam int          P_SHIFT = 26;

  // divide by 30600, exact for numerators up to 7818300
  localparam logic [23:0] QT_RECIP = 24'd8982939;
  localparam int          QT_SHIFT = 38;
  localparam logic [13:0] QT_BIAS  = 14'd15300;

  // hue wrap and sector width
  localparam logic [9:0] HUE_WRAP  = 10'd360;
  localparam logic [9:0] HUE_WRAP2 = 10'd720;
  localparam logic [5:0] SECT_SPAN = 6'd60;

  typedef logic [2:0] sector_t;

  localparam sector_t SECT_0 = 3'd0;
  localparam sector_t SECT_1 = 3'd1;
  localparam sector_t SECT_2 = 3'd2;
  localparam sector_t SECT_3 = 3'd3;
  localparam sector_t SECT_4 = 3'd4;
  localparam sector_t SECT_5 = 3'd5;

  // saturation, value and hue split, ready for the rgb stages
  typedef struct packed {
    logic [7:0] s;
    logic [7:0] v;
    sector_t    sector;
    logic [5:0] f;
    logic       grey;
    logic       black;
  } hsv_t;

  // word data that rides along with the color math
  typedef struct packed {
    logic [31:0] orig;
    logic        recolor;
  } side_t;

endpackage

### sv/mdhr_ifs.sv
// handshake channels of the mask driven hsv recolor block

// pixel pair input channel
interface mdhr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] orig_pixel;
  logic [31:0] mask_pixel;

  modport source (output valid, orig_pixel, mask_pixel, input ready);
  modport sink (input valid, orig_pixel, mask_pixel, output ready);
endinterface

// recolored pixel output channel
interface mdhr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_pixel;
  logic        recolored;

  modport source (output valid, new_pixel, recolored, input ready);
  modport sink (input valid, new_pixel, recolored, output ready);
endinterface

// register write channel
interface mdhr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mdhr_pkg::CFG_IDX_W-1:0]    index;
  logic [mdhr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/mask_driven_hsv_recolor.sv
// top level of the mask driven hsv recolor block
//
// Streams pixel pairs: pixel_in carries an original ARGB texel and a mask
// texel, pixel_out returns the recolored texel and a flag that tells whether
// it was recolored. Both use valid/ready; a word moves when both are high.
// The mask gray picks saturation and value, the programmed hue picks the
// color, the original alpha is kept. Gray of 250 or more passes the pixel.
// cfg writes hue_degrees (index 0), sat_gain_q8 (1) and val_gain_q8 (2);
// other indexes are dropped. cfg is always ready; write only while no pixel
// is in flight.
// Throughput is one pixel per cycle while pixel_out takes words. The word
// reaches pixel_out through six register stages, the first loaded at
// acceptance: luma sum and hue wrap, gray divide and hue sector, gain
// multiplies, hsv products, q/t numerators and p divide, q/t divide with
// the output register.
// When pixel_out stalls, each stage holds until the one after it frees,
// so bubbles close up and input is still taken while stages are empty.
// Reset sets hue 0, saturation gain 307 and value gain 896 and empties
// every stage.
module mask_driven_hsv_recolor (
  input  logic        clk,
  input  logic        rst,
  mdhr_cfg_if.sink    cfg,
  mdhr_in_if.sink     pixel_in,
  mdhr_out_if.source  pixel_out
);

  // configuration registers
  logic signed [mdhr_pkg::HUE_W-1:0] hue_degrees;
  logic [mdhr_pkg::GAIN_W-1:0]       sat_gain_q8;
  logic [mdhr_pkg::GAIN_W-1:0]       val_gain_q8;

  // stage 1 registers
  logic                 s1_valid;
  logic [31:0]          s1_orig;
  logic [14:0]          s1_sum;
  logic [8:0]           s1_hh;
  logic                 s1_grey;
  logic                 s1_black;

  // stage 2 registers
  logic                 s2_valid;
  logic [31:0]          s2_orig;
  logic [7:0]           s2_gray;
  mdhr_pkg::sector_t    s2_sector;
  logic [5:0]           s2_f;
  logic                 s2_grey;
  logic                 s2_black;

  // stage 3 registers
  logic                 s3_valid;
  mdhr_pkg::hsv_t       s3_hsv;
  mdhr_pkg::side_t      s3_side;

  logic rdy1, rdy2, rdy3;
  logic pipe_ready;

  // stage 1 logic
  logic [7:0]  mr, mg, mb;
  logic [14:0] sum_next;
  logic [9:0]  hue_u;
  logic [9:0]  hh_wide;

  // stage 2 logic
  logic [29:0]       gray_prod;
  mdhr_pkg::sector_t sector_next;
  logic [8:0]        sector_base;
  logic [8:0]        f_wide;

  // stage 3 logic
  logic [19:0]    s_prod;
  logic [19:0]    v_prod;
  logic [7:0]     s_next;
  logic [7:0]     v_next;
  mdhr_pkg::hsv_t hsv_next;

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_degrees <= '0;
      sat_gain_q8 <= 12'd307;
      val_gain_q8 <= 12'd896;
    end else if (cfg.valid) begin
      unique case (mdhr_pkg::cfg_reg_t'(cfg.index))
        mdhr_pkg::REG_HUE: hue_degrees <= cfg.data[mdhr_pkg::HUE_W-1:0];
        mdhr_pkg::REG_SAT: sat_gain_q8 <= cfg.data;
        mdhr_pkg::REG_VAL: val_gain_q8 <= cfg.data;
        default: ;
      endcase
    end
  end

  // ready chain back from the hsv stages
  assign rdy3           = !s3_valid || pipe_ready;
  assign rdy2           = !s2_valid || rdy3;
  assign rdy1           = !s1_valid || rdy2;
  assign pixel_in.ready = rdy1;

  // weighted luma sum of the mask
  assign mr       = pixel_in.mask_pixel[23:16];
  assign mg       = pixel_in.mask_pixel[15:8];
  assign mb       = pixel_in.mask_pixel[7:0];
  assign sum_next = ({7'd0, mr} * mdhr_pkg::LUMA_WR) + ({7'd0, mg} * mdhr_pkg::LUMA_WG)
                  + ({7'd0, mb} * mdhr_pkg::LUMA_WB);

  // hue wrap into 0..359
  assign hue_u = hue_degrees[9:0];

  always_comb begin
    priority if (hue_u >= mdhr_pkg::HUE_WRAP2) begin
      hh_wide = hue_u - mdhr_pkg::HUE_WRAP2;
    end else if (hue_u >= mdhr_pkg::HUE_WRAP) begin
      hh_wide = hue_u - mdhr_pkg::HUE_WRAP;
    end else begin
      hh_wide = hue_u;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= pixel_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_orig  <= pixel_in.orig_pixel;
      s1_sum   <= sum_next;
      s1_hh    <= hh_wide[8:0];
      s1_grey  <= (hue_degrees == -11'sd1);
      s1_black <= (hue_degrees < -11'sd1);
    end
  end

  // gray by reciprocal multiply
  assign gray_prod = 30'(s1_sum) * 30'(mdhr_pkg::GRAY_RECIP);

  // hue sector and fraction
  always_comb begin
    priority if (s1_hh >= 9'd300) begin
      sector_next = mdhr_pkg::SECT_5;
      sector_base = 9'd300;
    end else if (s1_hh >= 9'd240) begin
      sector_next = mdhr_pkg::SECT_4;
      sector_base = 9'd240;
    end else if (s1_hh >= 9'd180) begin
      sector_next = mdhr_pkg::SECT_3;
      sector_base = 9'd180;
    end else if (s1_hh >= 9'd120) begin
      sector_next = mdhr_pkg::SECT_2;
      sector_base = 9'd120;
    end else if (s1_hh >= 9'd60) begin
      sector_next = mdhr_pkg::SECT_1;
      sector_base = 9'd60;
    end else begin
      sector_next = mdhr_pkg::SECT_0;
      sector_base = 9'd0;
    end
  end

  assign f_wide = s1_hh - sector_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_orig   <= s1_orig;
      s2_gray   <= gray_prod[mdhr_pkg::GRAY_SHIFT +: 8];
      s2_sector <= sector_next;
      s2_f      <= f_wide[5:0];
      s2_grey   <= s1_grey;
      s2_black  <= s1_black;
    end
  end

  // saturation and value from the gains, clamped to 255
  assign s_prod = 20'(mdhr_pkg::FULL - s2_gray) * 20'(sat_gain_q8);
  assign v_prod = 20'(s2_gray) * 20'(val_gain_q8);
  assign s_next = (|s_prod[19:16]) ? mdhr_pkg::FULL : s_prod[15:8];
  assign v_next = (|v_prod[19:16]) ? mdhr_pkg::FULL : v_prod[15:8];

  always_comb begin
    hsv_next.s      = s_next;
    hsv_next.v      = v_next;
    hsv_next.sector = s2_sector;
    hsv_next.f      = s2_f;
    hsv_next.grey   = s2_grey || (s_next == 8'd0);
    hsv_next.black  = s2_black;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_hsv          <= hsv_next;
      s3_side.orig    <= s2_orig;
      s3_side.recolor <= (s2_gray < mdhr_pkg::GRAY_BRIGHT);
    end
  end

  // rgb conversion and output register
  mdhr_hsv_pipe u_hsv_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_ready  (pipe_ready),
    .in_hsv    (s3_hsv),
    .in_side   (s3_side),
    .pixel_out (pixel_out)
  );

endmodule

### sv/mdhr_hsv_pipe.sv
// hsv to rgb back end: three register stages ending in the output register
module mdhr_hsv_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mdhr_pkg::hsv_t    in_hsv,
  input  mdhr_pkg::side_t   in_side,
  mdhr_out_if.source        pixel_out
);

  // stage 1 registers
  logic                 p1_valid;
  logic [13:0]          p1_sf;
  logic [13:0]          p1_s60f;
  logic [16:0]          p1_pnum;
  logic [7:0]           p1_v;
  mdhr_pkg::sector_t    p1_sector;
  logic                 p1_grey;
  logic                 p1_black;
  mdhr_pkg::side_t      p1_side;

  // stage 2 registers
  logic                 p2_valid;
  logic [22:0]          p2_qnum;
  logic [22:0]          p2_tnum;
  logic [7:0]           p2_p;
  logic [7:0]           p2_v;
  mdhr_pkg::sector_t    p2_sector;
  logic                 p2_grey;
  logic                 p2_black;
  mdhr_pkg::side_t      p2_side;

  // output registers
  logic                 out_valid;
  logic [31:0]          new_pixel;
  logic                 recolored;

  logic rdy1, rdy2, rdy3;

  // stage 1 arithmetic
  logic [13:0] sf_next;
  logic [13:0] s60f_next;
  logic [15:0] vs_prod;
  logic [16:0] pnum_next;

  // stage 2 arithmetic
  logic [21:0] q_prod22;
  logic [21:0] t_prod22;
  logic [22:0] qnum_next;
  logic [22:0] tnum_next;
  logic [34:0] p_prod;

  // stage 3 arithmetic
  logic [46:0] q_prod;
  logic [46:0] t_prod;
  logic [7:0]  q_val;
  logic [7:0]  t_val;
  logic [7:0]  r_sel, g_sel, b_sel;
  logic [31:0] pixel_next;

  // ready chain, each stage frees when empty or when the next one moves
  assign rdy3     = !out_valid || pixel_out.ready;
  assign rdy2     = !p2_valid || rdy3;
  assign rdy1     = !p1_valid || rdy2;
  assign in_ready = rdy1;

  // products of saturation with the hue fraction, and the p numerator
  assign sf_next   = 14'(in_hsv.s) * 14'(in_hsv.f);
  assign s60f_next = 14'(in_hsv.s) * 14'(mdhr_pkg::SECT_SPAN - in_hsv.f);
  assign vs_prod   = 16'(in_hsv.v) * 16'(mdhr_pkg::FULL - in_hsv.s);
  assign pnum_next = {vs_prod, 1'b0} + 17'(mdhr_pkg::FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (rdy1) begin
      p1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1_sf     <= sf_next;
      p1_s60f   <= s60f_next;
      p1_pnum   <= pnum_next;
      p1_v      <= in_hsv.v;
      p1_sector <= in_hsv.sector;
      p1_grey   <= in_hsv.grey;
      p1_black  <= in_hsv.black;
      p1_side   <= in_side;
    end
  end

  // q and t numerators, p quotient
  assign q_prod22  = 22'(p1_v) * 22'(mdhr_pkg::QT_BIAS - p1_sf);
  assign t_prod22  = 22'(p1_v) * 22'(mdhr_pkg::QT_BIAS - p1_s60f);
  assign qnum_next = {q_prod22, 1'b0} + 23'(mdhr_pkg::QT_BIAS);
  assign tnum_next = {t_prod22, 1'b0} + 23'(mdhr_pkg::QT_BIAS);
  assign p_prod    = 35'(p1_pnum) * 35'(mdhr_pkg::P_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (rdy2) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_qnum   <= qnum_next;
      p2_tnum   <= tnum_next;
      p2_p      <= p_prod[mdhr_pkg::P_SHIFT +: 8];
      p2_v      <= p1_v;
      p2_sector <= p1_sector;
      p2_grey   <= p1_grey;
      p2_black  <= p1_black;
      p2_side   <= p1_side;
    end
  end

  // q and t quotients
  assign q_prod = 47'(p2_qnum) * 47'(mdhr_pkg::QT_RECIP);
  assign t_prod = 47'(p2_tnum) * 47'(mdhr_pkg::QT_RECIP);
  assign q_val  = q_prod[mdhr_pkg::QT_SHIFT +: 8];
  assign t_val  = t_prod[mdhr_pkg::QT_SHIFT +: 8];

  // sector select and special hues
  always_comb begin
    r_sel = p2_v;
    g_sel = p2_v;
    b_sel = p2_v;
    if (p2_black) begin
      r_sel = 8'd0;
      g_sel = 8'd0;
      b_sel = 8'd0;
    end else if (!p2_grey) begin
      unique case (p2_sector)
        mdhr_pkg::SECT_0: begin
          r_sel = p2_v;  g_sel = t_val; b_sel = p2_p;
        end
        mdhr_pkg::SECT_1: begin
          r_sel = q_val; g_sel = p2_v;  b_sel = p2_p;
        end
        mdhr_pkg::SECT_2: begin
          r_sel = p2_p;  g_sel = p2_v;  b_sel = t_val;
        end
        mdhr_pkg::SECT_3: begin
          r_sel = p2_p;  g_sel = q_val; b_sel = p2_v;
        end
        mdhr_pkg::SECT_4: begin
          r_sel = t_val; g_sel = p2_p;  b_sel = p2_v;
        end
        default: begin
          r_sel = p2_v;  g_sel = p2_p;  b_sel = q_val;
        end
      endcase
    end
  end

  // bright mask words pass the original pixel
  assign pixel_next = p2_side.recolor ? {p2_side.orig[31:24], r_sel, g_sel, b_sel}
                                      : p2_side.orig;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy3) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      new_pixel <= pixel_next;
      recolored <= p2_side.recolor;
    end
  end

  assign pixel_out.valid     = out_valid;
  assign pixel_out.new_pixel = new_pixel;
  assign pixel_out.recolored = recolored;

endmodule

### bench/mdhr_recolor_checker.sv
// checker for the mask driven hsv recolor block: watches the channels, predicts and compares
`timescale 1ns / 1ps

module mdhr_recolor_checker (
  input  logic clk,
  input  logic rst,
  mdhr_cfg_if  cfg,
  mdhr_in_if   pixel_in,
  mdhr_out_if  pixel_out,
  output int   errors,
  output int   pending,
  output int   n_recolored,
  output int   n_passed
);

  // one predicted output word
  typedef struct packed {
    logic [31:0] pixel;
    logic        recolored;
  } recolor_word_t;

  // shadow copy of the register file
  logic signed [mdhr_pkg::HUE_W-1:0] hue_deg;
  logic [mdhr_pkg::GAIN_W-1:0]       sat_gain;
  logic [mdhr_pkg::GAIN_W-1:0]       val_gain;

  recolor_word_t predicted_pixels[$];

  // mask gray, gains, then integer hsv to rgb with the programmed hue
  function automatic recolor_word_t recolor_pixel(
    input logic [31:0]                       orig,
    input logic [31:0]                       mask,
    input logic signed [mdhr_pkg::HUE_W-1:0] hue,
    input logic [mdhr_pkg::GAIN_W-1:0]       sgain,
    input logic [mdhr_pkg::GAIN_W-1:0]       vgain
  );
    int unsigned   gray, s, v, r, g, b, hh, f, p, q, t;
    int            hue_i;
    recolor_word_t w;
    gray = (30 * mask[23:16] + 59 * mask[15:8] + 11 * mask[7:0]) / 100;
    // bright mask passes the pixel through
    if (gray >= 250) begin
      w.pixel     = orig;
      w.recolored = 1'b0;
      return w;
    end
    s = ((255 - gray) * sgain) >> 8;
    if (s > 255) s = 255;
    v = (gray * vgain) >> 8;
    if (v > 255) v = 255;
    hue_i = hue;
    r = v;
    g = v;
    b = v;
    if (hue_i < -1) begin
      // hue below achromatic gives black
      r = 0;
      g = 0;
      b = 0;
    end else if (s != 0 && hue_i != -1) begin
      hh = hue_i % 360;
      f  = hh % 60;
      p  = (2 * v * (255 - s) + 255) / 510;
      q  = (2 * v * (15300 - s * f) + 15300) / 30600;
      t  = (2 * v * (15300 - s * (60 - f)) + 15300) / 30600;
      case (mdhr_pkg::sector_t'(hh / 60))
        mdhr_pkg::SECT_0: begin r = v; g = t; b = p; end
        mdhr_pkg::SECT_1: begin r = q; g = v; b = p; end
        mdhr_pkg::SECT_2: begin r = p; g = v; b = t; end
        mdhr_pkg::SECT_3: begin r = p; g = q; b = v; end
        mdhr_pkg::SECT_4: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
    end
    w.pixel     = {orig[31:24], r[7:0], g[7:0], b[7:0]};
    w.recolored = 1'b1;
    return w;
  endfunction

  // track register writes, predict on input words, compare on output words
  always @(posedge clk) begin
    recolor_word_t want;
    if (rst) begin
      hue_deg  = '0;
      sat_gain = 12'd307;
      val_gain = 12'd896;
      predicted_pixels.delete();
      errors      = 0;
      n_recolored = 0;
      n_passed    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mdhr_pkg::REG_HUE: hue_deg  = cfg.data[mdhr_pkg::HUE_W-1:0];
          mdhr_pkg::REG_SAT: sat_gain = cfg.data;
          mdhr_pkg::REG_VAL: val_gain = cfg.data;
          default: ;
        endcase
      end
      if (pixel_in.valid && pixel_in.ready)
        predicted_pixels.push_back(recolor_pixel(pixel_in.orig_pixel, pixel_in.mask_pixel,
                                                 hue_deg, sat_gain, val_gain));
      if (pixel_out.valid && pixel_out.ready) begin
        if (predicted_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected word new_pixel %h recolored %b", $time,
                   pixel_out.new_pixel, pixel_out.recolored);
        end else begin
          want = predicted_pixels.pop_front();
          if (want.recolored) n_recolored++;
          else n_passed++;
          if (pixel_out.new_pixel !== want.pixel) begin
            errors++;
            $display("%0t: new_pixel expected %h actual %h", $time, want.pixel,
                     pixel_out.new_pixel);
          end
          if (pixel_out.recolored !== want.recolored) begin
            errors++;
            $display("%0t: recolored expected %b actual %b", $time, want.recolored,
                     pixel_out.recolored);
          end
        end
      end
    end
    pending = predicted_pixels.size();
  end

endmodule

### bench/mask_driven_hsv_recolor_test.sv
// testbench top for the mask driven hsv recolor block: stimulus, register phases and verdict
`timescale 1ns / 1ps

module mask_driven_hsv_recolor_test;

  localparam logic [mdhr_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 63;

  logic clk;
  logic rst;

  mdhr_cfg_if cfg_ch ();
  mdhr_in_if  pix_in ();
  mdhr_out_if pix_out ();

  int errors, pending, n_recolored, n_passed;
  int n_items, n_writes, n_settings;
  int burst_left;
  int cycles;
  int rx_tick;

  mask_driven_hsv_recolor u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_ch),
    .pixel_in  (pix_in),
    .pixel_out (pix_out)
  );

  mdhr_recolor_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .pixel_in    (pix_in),
    .pixel_out   (pix_out),
    .errors      (errors),
    .pending     (pending),
    .n_recolored (n_recolored),
    .n_passed    (n_passed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: free running, random, then periodic stalls
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 211 < 60) begin
      pix_out.ready <= 1'b1;
    end else if (rx_tick % 211 < 140) begin
      pix_out.ready <= ($urandom_range(0, 3) != 0);
    end else begin
      pix_out.ready <= ((rx_tick % 9) < 5);
    end
  end

  // one register write, valid dropped afterwards
  task automatic write_reg(input logic [mdhr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mdhr_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    n_writes++;
  endtask

  // hue write, bit 11 of the data is don't care
  task automatic write_hue(input int hue);
    write_reg(mdhr_pkg::REG_HUE, {1'($urandom_range(0, 1)), 11'(hue)});
  endtask

  // one pixel pair, in bursts with random gaps in between
  task automatic send_pixel(input logic [31:0] orig, input logic [31:0] mask);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.orig_pixel <= orig;
    pix_in.mask_pixel <= mask;
    do @(posedge clk); while (!pix_in.ready);
    n_items++;
  endtask

  // stop sending and wait for every predicted word
  task automatic drain_results();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
  endtask

  // mostly random masks, some bright, some around the gray threshold
  function automatic logic [31:0] random_mask();
    case ($urandom_range(0, 7))
      0: return {8'($urandom), 8'($urandom_range(250, 255)), 8'($urandom_range(250, 255)),
                 8'($urandom_range(250, 255))};
      1: return {8'($urandom), 8'($urandom_range(246, 253)), 8'($urandom_range(246, 253)),
                 8'($urandom_range(246, 253))};
      default: return $urandom;
    endcase
  endfunction

  // dark enough mask to always recolor
  function automatic logic [31:0] dark_mask();
    return {8'($urandom), 8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
            8'($urandom_range(0, 200))};
  endfunction

  function automatic logic [mdhr_pkg::GAIN_W-1:0] random_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 12'd256;
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  initial begin
    int hue_list[14] = '{0, 30, 60, 90, 150, 210, 270, 330, 359, 360, 1023, -1, -2, -512};
    int hue_picks[7] = '{-512, -2, -1, 0, 359, 360, 1023};
    int hue;
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    pix_in.valid      = 1'b0;
    pix_in.orig_pixel = '0;
    pix_in.mask_pixel = '0;
    pix_out.ready     = 1'b0;
    cycles            = 0;
    rx_tick           = 0;
    burst_left        = 0;
    n_items           = 0;
    n_writes          = 0;
    n_settings        = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: field extremes and both sides of the gray threshold
    send_pixel(32'h0000_0000, 32'h0000_0000);
    send_pixel(32'hffff_ffff, 32'hffff_ffff);
    send_pixel(32'h1234_5678, 32'h00f9_f9f9);
    send_pixel(32'ha5a5_a5a5, 32'h00fa_fafa);
    send_pixel(32'h80ff_00ff, 32'hff7f_7f7f);
    drain_results();

    // every hue sector, wrap, achromatic and black
    foreach (hue_list[i]) begin
      write_hue(hue_list[i]);
      n_settings++;
      send_pixel($urandom, dark_mask());
      drain_results();
    end

    // zero saturation, full gains, zero value, dropped register index
    write_hue(200);
    write_reg(mdhr_pkg::REG_SAT, 12'd0);
    send_pixel($urandom, dark_mask());
    drain_results();
    write_reg(mdhr_pkg::REG_SAT, 12'hfff);
    write_reg(mdhr_pkg::REG_VAL, 12'hfff);
    write_reg(REG_NONE, 12'h000);
    send_pixel($urandom, dark_mask());
    drain_results();
    write_reg(mdhr_pkg::REG_VAL, 12'd0);
    send_pixel($urandom, dark_mask());
    drain_results();
    n_settings += 3;

    // random phases, each with its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      hue = ($urandom_range(0, 3) == 0) ? hue_picks[$urandom_range(0, 6)]
                                        : int'($urandom_range(0, 1535)) - 512;
      write_hue(hue);
      write_reg(mdhr_pkg::REG_SAT, random_gain());
      write_reg(mdhr_pkg::REG_VAL, random_gain());
      if ($urandom_range(0, 1) == 1) write_reg(REG_NONE, 12'($urandom));
      n_settings++;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_pixel($urandom, random_mask());
        // hold off mid-phase until the pipe is empty
        if (ph == 3 && k == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
    end

    repeat (12) @(negedge clk);
    $display("sent %0d pixel pairs: %0d recolored, %0d passed through", n_items,
             n_recolored, n_passed);
    $display("used %0d register settings over %0d register writes", n_settings, n_writes);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
